// File: rtl/fli_pkg.sv
// shared types and constants of the line-delta chunk decoder
package fli_pkg;

  // configuration and field widths
  localparam int PITCH_W = 12;
  localparam int COUNT_W = 16;
  localparam int AMT_W   = COUNT_W + PITCH_W;
  localparam int OUT_ADDR_W = 20;

  // back-end operation codes
  localparam logic [1:0] OP_NOP     = 2'd0;
  localparam logic [1:0] OP_SKIP    = 2'd1;
  localparam logic [1:0] OP_COL_ADD = 2'd2;
  localparam logic [1:0] OP_EMIT    = 2'd3;

  // configuration register indexes
  localparam logic REG_LINE_PITCH = 1'b0;

  // command handed from the parser to the address engine
  typedef struct packed {
    logic [1:0]       op;
    logic             col_load;
    logic             next_line;
    logic             clear;
    logic [AMT_W-1:0] amt;
    logic [7:0]       value;
    logic [7:0]       len;
  } cmd_t;

endpackage

// File: rtl/fli_stream_if.sv
// valid/ready channel interfaces for chunk bytes and write spans
interface fli_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       chunk_end;

  modport source (output valid, output data_byte, output chunk_end, input ready);
  modport sink (input valid, input data_byte, input chunk_end, output ready);
endinterface

interface fli_out_if;
  logic        valid;
  logic        ready;
  logic [19:0] write_addr;
  logic [7:0]  write_value;
  logic [7:0]  span_length;

  modport source (output valid, output write_addr, output write_value,
                  output span_length, input ready);
  modport sink (input valid, input write_addr, input write_value,
                input span_length, output ready);
endinterface

// File: rtl/fli_cmd_fifo.sv
// short command queue between the chunk parser and the address engine
module fli_cmd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fli_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output fli_pkg::cmd_t head_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fli_pkg::cmd_t     mem_r [DEPTH];
  logic [PTR_W-1:0]  wptr_r, wptr_nxt;
  logic [PTR_W-1:0]  rptr_r, rptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_cmd = mem_r[rptr_r];

  // pointer and fill count update
  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_cmd;
    end
  end

  // queue never overruns, underruns or overcounts
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("command pushed into full queue");
  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("command popped from empty queue");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("queue count did not follow a push");

endmodule

// File: rtl/fli_front.sv
// chunk parser: walks the header, line and packet structure byte by byte
module fli_front (
  input  logic                        clk,
  input  logic                        rst_n,
  fli_in_if.sink                      in_bus,
  input  logic [fli_pkg::PITCH_W-1:0] pitch,
  input  logic                        q_full,
  output logic                        q_push,
  output fli_pkg::cmd_t               q_cmd
);

  localparam logic [3:0] PH_SKIP_LO = 4'd0;
  localparam logic [3:0] PH_SKIP_HI = 4'd1;
  localparam logic [3:0] PH_CNT_LO  = 4'd2;
  localparam logic [3:0] PH_CNT_HI  = 4'd3;
  localparam logic [3:0] PH_PACKETS = 4'd4;
  localparam logic [3:0] PH_COLSKIP = 4'd5;
  localparam logic [3:0] PH_RUN     = 4'd6;
  localparam logic [3:0] PH_LITERAL = 4'd7;
  localparam logic [3:0] PH_REPEAT  = 4'd8;

  logic [3:0]                  phase_r, phase_nxt;
  logic [7:0]                  hold_r, hold_nxt;
  logic [fli_pkg::COUNT_W-1:0] lines_r, lines_nxt;
  logic [7:0]                  packets_r, packets_nxt;
  logic [6:0]                  literals_r, literals_nxt;

  logic                        fire;
  logic [7:0]                  b;
  logic [fli_pkg::COUNT_W-1:0] word;
  logic [fli_pkg::COUNT_W-1:0] lines_dec;
  logic [7:0]                  packets_dec;
  logic [6:0]                  literals_dec;
  logic                        end_packet;
  logic                        end_line;
  fli_pkg::cmd_t               cmd;

  assign in_bus.ready = !q_full;
  assign fire         = in_bus.valid && in_bus.ready;
  assign b            = in_bus.data_byte;
  assign word         = {b, hold_r};
  assign lines_dec    = lines_r - fli_pkg::COUNT_W'(1);
  assign packets_dec  = packets_r - 8'd1;
  assign literals_dec = literals_r - 7'd1;

  // next parse state and command for this byte
  always_comb begin
    phase_nxt    = phase_r;
    hold_nxt     = hold_r;
    lines_nxt    = lines_r;
    packets_nxt  = packets_r;
    literals_nxt = literals_r;
    end_packet   = 1'b0;
    end_line     = 1'b0;
    cmd          = '0;
    cmd.op       = fli_pkg::OP_NOP;

    case (phase_r)
      PH_SKIP_HI: begin
        cmd.op    = fli_pkg::OP_SKIP;
        cmd.amt   = fli_pkg::AMT_W'(word) * fli_pkg::AMT_W'(pitch);
        phase_nxt = PH_CNT_LO;
      end
      PH_CNT_LO: begin
        hold_nxt  = b;
        phase_nxt = PH_CNT_HI;
      end
      PH_CNT_HI: begin
        lines_nxt = word;
        phase_nxt = (word == '0) ? PH_SKIP_LO : PH_PACKETS;
      end
      PH_PACKETS: begin
        packets_nxt  = b;
        cmd.col_load = 1'b1;
        if (b == 8'd0) begin
          end_line = 1'b1;
        end else begin
          phase_nxt = PH_COLSKIP;
        end
      end
      PH_COLSKIP: begin
        cmd.op    = fli_pkg::OP_COL_ADD;
        cmd.amt   = fli_pkg::AMT_W'(b);
        phase_nxt = PH_RUN;
      end
      PH_RUN: begin
        if (b == 8'd0) begin
          end_packet = 1'b1;
        end else if (!b[7]) begin
          literals_nxt = b[6:0];
          phase_nxt    = PH_LITERAL;
        end else begin
          hold_nxt  = b;
          phase_nxt = PH_REPEAT;
        end
      end
      PH_LITERAL: begin
        cmd.op       = fli_pkg::OP_EMIT;
        cmd.value    = b;
        cmd.len      = 8'd1;
        literals_nxt = literals_dec;
        end_packet   = (literals_dec == 7'd0);
      end
      PH_REPEAT: begin
        cmd.op     = fli_pkg::OP_EMIT;
        cmd.value  = b;
        cmd.len    = 8'(9'd256 - {1'b0, hold_r});
        end_packet = 1'b1;
      end
      default: begin
        hold_nxt  = b;
        phase_nxt = PH_SKIP_HI;
      end
    endcase

    // packet done: next packet or end of line
    if (end_packet) begin
      packets_nxt = packets_dec;
      if (packets_dec == 8'd0) begin
        end_line = 1'b1;
      end else begin
        phase_nxt = PH_COLSKIP;
      end
    end

    // line done: step line base, next line or next header
    if (end_line) begin
      cmd.next_line = 1'b1;
      lines_nxt     = lines_dec;
      phase_nxt     = (lines_dec == '0) ? PH_SKIP_LO : PH_PACKETS;
    end

    // last byte of the chunk returns everything to reset
    if (in_bus.chunk_end) begin
      cmd.clear    = 1'b1;
      phase_nxt    = PH_SKIP_LO;
      hold_nxt     = '0;
      lines_nxt    = '0;
      packets_nxt  = '0;
      literals_nxt = '0;
    end
  end

  assign q_cmd  = cmd;
  assign q_push = fire && ((cmd.op != fli_pkg::OP_NOP) || cmd.col_load ||
                           cmd.next_line || cmd.clear);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_SKIP_LO;
      hold_r     <= '0;
      lines_r    <= '0;
      packets_r  <= '0;
      literals_r <= '0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      hold_r     <= hold_nxt;
      lines_r    <= lines_nxt;
      packets_r  <= packets_nxt;
      literals_r <= literals_nxt;
    end
  end

endmodule

// File: rtl/fli_back.sv
// address engine: keeps line and column addresses and drives write spans
module fli_back #(
  parameter int ADDR_BITS = 20
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [fli_pkg::PITCH_W-1:0] pitch,
  input  logic                        q_empty,
  input  fli_pkg::cmd_t               q_cmd,
  output logic                        q_pop,
  fli_out_if.source                   out_bus
);

  logic [ADDR_BITS-1:0] line_r, line_nxt;
  logic [ADDR_BITS-1:0] col_r, col_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [ADDR_BITS-1:0] out_addr_r;
  logic [7:0]           out_value_r;
  logic [7:0]           out_len_r;
  logic [ADDR_BITS+fli_pkg::OUT_ADDR_W-1:0] addr_ext;
  logic                 is_emit;
  logic                 out_free;

  assign is_emit  = (q_cmd.op == fli_pkg::OP_EMIT);
  assign out_free = !out_valid_r || out_bus.ready;
  assign q_pop    = !q_empty && (!is_emit || out_free);

  // apply one command to the address state
  always_comb begin
    line_nxt = line_r;
    col_nxt  = col_r;
    if (q_pop) begin
      if (q_cmd.col_load) begin
        col_nxt = line_r;
      end
      case (q_cmd.op)
        fli_pkg::OP_SKIP:    line_nxt = line_r + q_cmd.amt[ADDR_BITS-1:0];
        fli_pkg::OP_COL_ADD: col_nxt = col_nxt + q_cmd.amt[ADDR_BITS-1:0];
        fli_pkg::OP_EMIT:    col_nxt = col_nxt + ADDR_BITS'(q_cmd.len);
        default: ;
      endcase
      if (q_cmd.next_line) begin
        line_nxt = line_nxt + ADDR_BITS'(pitch);
      end
      if (q_cmd.clear) begin
        line_nxt = '0;
        col_nxt  = '0;
      end
    end
  end

  // output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop && is_emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r      <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      line_r      <= line_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // span payload, address taken before the column moves
  always_ff @(posedge clk) begin
    if (q_pop && is_emit) begin
      out_addr_r  <= q_cmd.col_load ? line_r : col_r;
      out_value_r <= q_cmd.value;
      out_len_r   <= q_cmd.len;
    end
  end

  assign addr_ext            = {{fli_pkg::OUT_ADDR_W{1'b0}}, out_addr_r};
  assign out_bus.valid       = out_valid_r;
  assign out_bus.write_addr  = addr_ext[fli_pkg::OUT_ADDR_W-1:0];
  assign out_bus.write_value = out_value_r;
  assign out_bus.span_length = out_len_r;

endmodule

// File: rtl/fli_line_delta_decoder_unit.sv
// top level of the line-delta chunk decoder
// in_bus carries one chunk byte per beat, with chunk_end set on the final
// byte of a chunk. out_bus carries one write span per beat: frame-relative
// address, byte value and run length (1 for a literal, up to 128 for a
// repeat). line_pitch is set through the APB port at byte address 0 and
// should only be written while no chunk is in flight.
// A byte is taken every cycle while the queue has room; each span
// is registered. The parser pushes commands into a small queue and the
// address engine drains one per cycle, so throughput is one byte per cycle
// as long as spans are taken. When out_bus stalls, the held span waits in
// the output register, the engine keeps executing non-writing commands and
// the queue fills; in_bus.ready drops only once FIFO_DEPTH commands wait.
// Reset clears the parser to expect a line skip, zeroes the line and column
// addresses, empties the queue and sets line_pitch to 320. A chunk_end byte
// also returns the parse and address state to reset after its own span.
module fli_line_delta_decoder_unit #(
  parameter int ADDR_BITS  = 20,
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  fli_in_if.sink      in_bus,
  fli_out_if.source   out_bus,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [fli_pkg::PITCH_W-1:0] pitch_r;
  logic                        cfg_write;
  logic                        q_push;
  logic                        q_pop;
  logic                        q_full;
  logic                        q_empty;
  fli_pkg::cmd_t               push_cmd;
  fli_pkg::cmd_t               head_cmd;

  // configuration register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == fli_pkg::REG_LINE_PITCH) ?
                     {{(32 - fli_pkg::PITCH_W){1'b0}}, pitch_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r <= fli_pkg::PITCH_W'(320);
    end else if (cfg_write && (paddr[2] == fli_pkg::REG_LINE_PITCH)) begin
      pitch_r <= pwdata[fli_pkg::PITCH_W-1:0];
    end
  end

  fli_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .pitch  (pitch_r),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (push_cmd)
  );

  fli_cmd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_cmd (head_cmd)
  );

  fli_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .pitch   (pitch_r),
    .q_empty (q_empty),
    .q_cmd   (head_cmd),
    .q_pop   (q_pop),
    .out_bus (out_bus)
  );

endmodule
